>>> hw/rtl/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types, codes and colour helpers for the pixel stream decoder.
// ----------------------------------------------------------------------------
package tpd_pkg;

    localparam int MAP_DEPTH_DEFAULT = 256;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_DATA_W  = 40;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_KIND      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_ENTRY_BYTES = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_ORIGIN      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_LENGTH      = 3'd4;

    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_IMAGE = 1'b1;

    typedef enum logic [2:0] {
        KIND_INDEXED     = 3'd0,
        KIND_TRUE        = 3'd1,
        KIND_GRAY        = 3'd2,
        KIND_RLE_INDEXED = 3'd3,
        KIND_RLE_TRUE    = 3'd4
    } kind_t;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [6:0] RLE_COUNT_MASK = 7'h7f;

    localparam logic [7:0] EXPAND5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    typedef struct packed {
        logic [2:0]  image_kind;
        logic [2:0]  pixel_bytes;
        logic [2:0]  map_entry_bytes;
        logic [15:0] map_origin;
        logic [8:0]  map_length;
    } cfg_t;

    typedef struct packed {
        logic        emit;
        logic        from_pal;
        logic [31:0] rgba;
        logic [7:0]  rep;
    } pix_t;

    function automatic logic [2:0] clamp_colour_bytes(input logic [2:0] n);
        logic [2:0] r;
        if (n < 3'd2) begin
            r = 3'd2;
        end else if (n > 3'd4) begin
            r = 3'd4;
        end else begin
            r = n;
        end
        return r;
    endfunction

    function automatic logic [31:0] decode_colour(input logic [31:0] raw,
                                                  input logic [2:0]  nbytes);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        if (nbytes == 3'd2) begin
            r = EXPAND5[raw[14:10]];
            g = EXPAND5[raw[9:5]];
            b = EXPAND5[raw[4:0]];
            a = raw[15] ? ALPHA_CLEAR : ALPHA_OPAQUE;
        end else begin
            b = raw[7:0];
            g = raw[15:8];
            r = raw[23:16];
            a = (nbytes == 3'd4 && raw[31:24] != 8'd0) ? ALPHA_CLEAR : ALPHA_OPAQUE;
        end
        return {r, g, b, a};
    endfunction

endpackage

>>> hw/rtl/tpd_palette.sv
// ----------------------------------------------------------------------------
// tpd_palette
// Palette memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tpd_palette
    import tpd_pkg::*;
#(
    parameter int MAP_DEPTH = MAP_DEPTH_DEFAULT,
    localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [MAP_DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/tpd_byte_decode.sv
// ----------------------------------------------------------------------------
// tpd_byte_decode
// Byte gathering, packet tracking and colour decode for one byte per cycle.
// ----------------------------------------------------------------------------
module tpd_byte_decode
    import tpd_pkg::*;
#(
    parameter int MAP_DEPTH = MAP_DEPTH_DEFAULT,
    localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1,
    localparam int FW = $clog2(MAP_DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  logic          op,
    input  logic [7:0]    data_byte,
    input  cfg_t          cfg,
    output pix_t          result,
    output logic          pal_wr_en,
    output logic [AW-1:0] pal_wr_addr,
    output logic [31:0]   pal_wr_data,
    output logic          pal_rd_en,
    output logic [AW-1:0] pal_rd_addr
);

    logic [FW-1:0] fill_reg, fill_next;
    logic [31:0]   map_gather_reg, map_gather_next;
    logic [1:0]    map_cnt_reg, map_cnt_next;
    logic [31:0]   pix_gather_reg, pix_gather_next;
    logic [1:0]    pix_cnt_reg, pix_cnt_next;
    logic          open_reg, open_next;
    logic          is_run_reg, is_run_next;
    logic [7:0]    left_reg, left_next;

    logic [2:0]  need_map;
    logic [2:0]  map_cnt1;
    logic [31:0] map_raw;
    logic        map_done;
    logic        fill_room;
    logic        indexed;
    logic [2:0]  need_pix;
    logic [2:0]  pix_cnt1;
    logic [31:0] pix_raw;
    logic        pix_done;
    logic [31:0] pix_rgba;
    logic        idx_below;
    logic [15:0] idx;
    logic        idx_ok;
    logic [7:0]  left_dec;

    always_comb begin
        need_map  = clamp_colour_bytes(cfg.map_entry_bytes);
        map_cnt1  = {1'b0, map_cnt_reg} + 3'd1;
        map_raw   = map_gather_reg | ({24'd0, data_byte} << {map_cnt_reg, 3'b000});
        map_done  = map_cnt1 >= need_map;
        fill_room = fill_reg < FW'(MAP_DEPTH);

        indexed  = (cfg.image_kind == KIND_INDEXED) || (cfg.image_kind == KIND_RLE_INDEXED);
        need_pix = indexed ? ((cfg.pixel_bytes <= 3'd1) ? 3'd1 : 3'd2)
                           : clamp_colour_bytes(cfg.pixel_bytes);
        pix_cnt1 = {1'b0, pix_cnt_reg} + 3'd1;
        pix_raw  = pix_gather_reg | ({24'd0, data_byte} << {pix_cnt_reg, 3'b000});
        pix_done = pix_cnt1 >= need_pix;
        pix_rgba = decode_colour(pix_raw, need_pix);

        idx_below = pix_raw[15:0] < cfg.map_origin;
        idx       = pix_raw[15:0] - cfg.map_origin;
        idx_ok    = !idx_below && ({1'b0, idx} < {8'd0, cfg.map_length})
                    && ({1'b0, idx} < 17'(MAP_DEPTH));
        left_dec  = left_reg - 8'd1;
    end

    always_comb begin
        fill_next       = fill_reg;
        map_gather_next = map_gather_reg;
        map_cnt_next    = map_cnt_reg;
        pix_gather_next = pix_gather_reg;
        pix_cnt_next    = pix_cnt_reg;
        open_next       = open_reg;
        is_run_next     = is_run_reg;
        left_next       = left_reg;
        result          = '0;
        pal_wr_en       = 1'b0;
        pal_wr_addr     = fill_reg[AW-1:0];
        pal_wr_data     = decode_colour(map_raw, need_map);
        pal_rd_en       = 1'b0;
        pal_rd_addr     = idx_ok ? idx[AW-1:0] : '0;

        if (fire) begin
            if (op == OP_MAP) begin
                if (map_done) begin
                    if (fill_room) begin
                        pal_wr_en = 1'b1;
                        fill_next = fill_reg + FW'(1);
                    end
                    map_gather_next = '0;
                    map_cnt_next    = '0;
                end else begin
                    map_gather_next = map_raw;
                    map_cnt_next    = map_cnt1[1:0];
                end
            end else begin
                case (cfg.image_kind)
                    KIND_INDEXED, KIND_TRUE: begin
                        if (pix_done) begin
                            pix_gather_next = '0;
                            pix_cnt_next    = '0;
                            result.emit     = 1'b1;
                            result.from_pal = indexed;
                            result.rgba     = pix_rgba;
                            result.rep      = 8'd1;
                            pal_rd_en       = indexed;
                        end else begin
                            pix_gather_next = pix_raw;
                            pix_cnt_next    = pix_cnt1[1:0];
                        end
                    end
                    KIND_GRAY: begin
                        result.emit = 1'b1;
                        result.rgba = {data_byte, data_byte, data_byte, ALPHA_OPAQUE};
                        result.rep  = 8'd1;
                    end
                    KIND_RLE_INDEXED, KIND_RLE_TRUE: begin
                        if (!open_reg) begin
                            is_run_next     = data_byte[7];
                            left_next       = {1'b0, data_byte[6:0] & RLE_COUNT_MASK} + 8'd1;
                            open_next       = 1'b1;
                            pix_gather_next = '0;
                            pix_cnt_next    = '0;
                        end else if (pix_done) begin
                            pix_gather_next = '0;
                            pix_cnt_next    = '0;
                            result.emit     = 1'b1;
                            result.from_pal = indexed;
                            result.rgba     = pix_rgba;
                            pal_rd_en       = indexed;
                            if (is_run_reg) begin
                                result.rep = left_reg;
                                left_next  = '0;
                                open_next  = 1'b0;
                            end else begin
                                result.rep = 8'd1;
                                left_next  = left_dec;
                                if (left_dec == 8'd0) begin
                                    open_next = 1'b0;
                                end
                            end
                        end else begin
                            pix_gather_next = pix_raw;
                            pix_cnt_next    = pix_cnt1[1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            map_gather_reg <= '0;
            map_cnt_reg    <= '0;
            pix_gather_reg <= '0;
            pix_cnt_reg    <= '0;
            open_reg       <= 1'b0;
            is_run_reg     <= 1'b0;
            left_reg       <= '0;
        end else begin
            fill_reg       <= fill_next;
            map_gather_reg <= map_gather_next;
            map_cnt_reg    <= map_cnt_next;
            pix_gather_reg <= pix_gather_next;
            pix_cnt_reg    <= pix_cnt_next;
            open_reg       <= open_next;
            is_run_reg     <= is_run_next;
            left_reg       <= left_next;
        end
    end

endmodule

>>> hw/rtl/tga_pixel_stream_decoder_core.sv
// A pixel's last byte goes through the s1, s2 and output registers to m_tvalid.
// One byte per cycle unless stalled; each byte makes at most one palette write or read.
// Each stage holds only while the stage after it is full and stalled.
// Reset clears the pipeline, the gather and packet state and loads register defaults.
// Palette contents are undefined after reset and need no clearing pass.
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_core
// Streams image-file bytes in and decoded RGBA pixels with repeat counts out.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_core
    import tpd_pkg::*;
#(
    parameter int MAP_DEPTH = MAP_DEPTH_DEFAULT,
    localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic [0:0]             s_tuser,   // [0] opcode

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                              // [31:24] alpha, [39:32] repeat_res

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg_reg;

    logic       s1_valid_reg;
    logic       s1_op_reg;
    logic [7:0] s1_byte_reg;

    logic        s2_valid_reg;
    logic        s2_from_pal_reg;
    logic [31:0] s2_rgba_reg;
    logic [7:0]  s2_rep_reg;

    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic out_en;
    logic s2_en;
    logic s1_en;
    logic fire;

    pix_t          result;
    logic          pal_wr_en;
    logic [AW-1:0] pal_wr_addr;
    logic [31:0]   pal_wr_data;
    logic          pal_rd_en;
    logic [AW-1:0] pal_rd_addr;
    logic [31:0]   pal_rd_data;
    logic [31:0]   s2_pixel;

    assign out_en = !m_valid_reg || m_tready;
    assign s2_en  = !s2_valid_reg || out_en;
    assign s1_en  = !s1_valid_reg || s2_en;
    assign fire   = s1_valid_reg && s2_en;

    assign s_tready  = s1_en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_kind      <= KIND_TRUE;
            cfg_reg.pixel_bytes     <= 3'd3;
            cfg_reg.map_entry_bytes <= 3'd3;
            cfg_reg.map_origin      <= '0;
            cfg_reg.map_length      <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_IMAGE_KIND:      cfg_reg.image_kind      <= cfg_data[2:0];
                REG_PIXEL_BYTES:     cfg_reg.pixel_bytes     <= cfg_data[2:0];
                REG_MAP_ENTRY_BYTES: cfg_reg.map_entry_bytes <= cfg_data[2:0];
                REG_MAP_ORIGIN:      cfg_reg.map_origin      <= cfg_data[15:0];
                REG_MAP_LENGTH:      cfg_reg.map_length      <= cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    tpd_byte_decode #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .op          (s1_op_reg),
        .data_byte   (s1_byte_reg),
        .cfg         (cfg_reg),
        .result      (result),
        .pal_wr_en   (pal_wr_en),
        .pal_wr_addr (pal_wr_addr),
        .pal_wr_data (pal_wr_data),
        .pal_rd_en   (pal_rd_en),
        .pal_rd_addr (pal_rd_addr)
    );

    tpd_palette #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (pal_wr_en),
        .wr_addr (pal_wr_addr),
        .wr_data (pal_wr_data),
        .rd_en   (pal_rd_en),
        .rd_addr (pal_rd_addr),
        .rd_data (pal_rd_data)
    );

    assign s2_pixel = s2_from_pal_reg ? pal_rd_data : s2_rgba_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_en) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_en) begin
                s2_valid_reg <= fire && result.emit;
            end
            if (out_en) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_en) begin
            s1_op_reg   <= s_tuser[0];
            s1_byte_reg <= s_tdata;
        end
        if (s2_en) begin
            s2_from_pal_reg <= result.from_pal;
            s2_rgba_reg     <= result.rgba;
            s2_rep_reg      <= result.rep;
        end
        if (out_en) begin
            m_data_reg <= {s2_rep_reg, s2_pixel[7:0], s2_pixel[15:8],
                           s2_pixel[23:16], s2_pixel[31:24]};
        end
    end

endmodule
